[rtl/ppst_pkg.sv]
// Shared types, widths and constants for the phase, scale and threshold core.
`timescale 1ns / 1ps
`default_nettype none

package ppst_pkg;

   localparam int SAMPLE_W  = 24;
   localparam int IDX_W     = 16;
   localparam int SCALE_W   = 25;
   localparam int THRESH_W  = 48;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;

   // Index bits that take part in the phase and pass through to the result.
   localparam int INDEX_BITS = 16;
   localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'((64'd1 << INDEX_BITS) - 64'd1);

   localparam logic signed [SAMPLE_W-1:0] MAX_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] MIN_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

   localparam logic [SCALE_W-1:0]  SCALE_RESET  = SCALE_W'(1) << (SCALE_W - 1);
   localparam logic [THRESH_W-1:0] THRESH_RESET = '0;

   // Register index, taken from the 8-byte word address.
   localparam logic REG_SCALE     = 1'b0;
   localparam logic REG_THRESHOLD = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_re;
      logic signed [SAMPLE_W-1:0] sample_im;
      logic [IDX_W-1:0]           row_x;
      logic [IDX_W-1:0]           col_z;
      logic                       last_item;
   } req_type;

   typedef struct packed {
      logic                       keep;
      logic [IDX_W-1:0]           out_x;
      logic [IDX_W-1:0]           out_z;
      logic signed [SAMPLE_W-1:0] coeff_re;
      logic signed [SAMPLE_W-1:0] coeff_im;
      logic                       last_out;
   } rsp_type;

   // Coefficient in flight between stages.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
      logic [IDX_W-1:0]           x;
      logic [IDX_W-1:0]           z;
      logic                       last;
   } item_type;

endpackage

`default_nettype wire

[rtl/ppst_csr.sv]
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module ppst_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [ppst_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [ppst_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ppst_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                    csr_pready,
   output logic [ppst_pkg::SCALE_W-1:0]            scale,
   output logic [ppst_pkg::THRESH_W-1:0]           threshold_sq
);

   logic [ppst_pkg::SCALE_W-1:0]  scale_ff, scale_in;
   logic [ppst_pkg::THRESH_W-1:0] thresh_ff, thresh_in;
   logic                          wr_en;
   logic                          reg_sel;

   assign wr_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel = csr_paddr[3];

   always_comb begin
      scale_in  = scale_ff;
      thresh_in = thresh_ff;
      if (wr_en) begin
         unique case (reg_sel)
            ppst_pkg::REG_SCALE:     scale_in  = csr_pwdata[ppst_pkg::SCALE_W-1:0];
            ppst_pkg::REG_THRESHOLD: thresh_in = csr_pwdata[ppst_pkg::THRESH_W-1:0];
            default:                 scale_in  = scale_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= ppst_pkg::SCALE_RESET;
         thresh_ff <= ppst_pkg::THRESH_RESET;
      end else begin
         scale_ff  <= scale_in;
         thresh_ff <= thresh_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         ppst_pkg::REG_SCALE:     csr_prdata = ppst_pkg::CSR_DATA_W'(scale_ff);
         ppst_pkg::REG_THRESHOLD: csr_prdata = ppst_pkg::CSR_DATA_W'(thresh_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   assign csr_pready   = 1'b1;
   assign scale        = scale_ff;
   assign threshold_sq = thresh_ff;

endmodule

`default_nettype wire

[rtl/ppst_phase.sv]
// Stage 1: index mask, popcount of x AND z modulo 4, and phase rotation.
`timescale 1ns / 1ps
`default_nettype none

module ppst_phase (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire ppst_pkg::req_type  in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output ppst_pkg::item_type      out_data
);

   function automatic logic signed [ppst_pkg::SAMPLE_W-1:0] sat_neg(
      input logic signed [ppst_pkg::SAMPLE_W-1:0] v
   );
      logic signed [ppst_pkg::SAMPLE_W-1:0] r;
      r = (v == ppst_pkg::MIN_NEG) ? ppst_pkg::MAX_POS : -v;
      return r;
   endfunction

   logic                  valid_ff, valid_in;
   ppst_pkg::item_type    data_ff, data_in;
   logic                  stage_en;
   logic [ppst_pkg::IDX_W-1:0] x_m, z_m;
   logic [1:0]            k;

   assign stage_en = !valid_ff || out_ready;
   assign in_ready = stage_en;
   assign valid_in = stage_en ? in_valid : valid_ff;

   assign x_m = in_data.row_x & ppst_pkg::IDX_MASK;
   assign z_m = in_data.col_z & ppst_pkg::IDX_MASK;
   assign k   = 2'($countones(x_m & z_m));

   always_comb begin
      data_in.x    = x_m;
      data_in.z    = z_m;
      data_in.last = in_data.last_item;
      unique case (k)
         2'd0: begin
            data_in.re = in_data.sample_re;
            data_in.im = in_data.sample_im;
         end
         2'd1: begin
            data_in.re = in_data.sample_im;
            data_in.im = sat_neg(in_data.sample_re);
         end
         2'd2: begin
            data_in.re = sat_neg(in_data.sample_re);
            data_in.im = sat_neg(in_data.sample_im);
         end
         default: begin
            data_in.re = sat_neg(in_data.sample_im);
            data_in.im = in_data.sample_re;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[rtl/ppst_scale.sv]
// Stages 2 and 3: multiply by scale, then floor-shift and saturate to Q1.22.
`timescale 1ns / 1ps
`default_nettype none

module ppst_scale (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [ppst_pkg::SCALE_W-1:0]  scale,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire ppst_pkg::item_type            in_data,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output ppst_pkg::item_type                 out_data
);

   localparam int PROD_W = ppst_pkg::SAMPLE_W + ppst_pkg::SCALE_W + 1;
   localparam int FRAC_W = ppst_pkg::SCALE_W - 1;
   localparam int Q_W    = PROD_W - FRAC_W;

   function automatic logic signed [ppst_pkg::SAMPLE_W-1:0] sat_q(
      input logic signed [Q_W-1:0] q
   );
      logic signed [ppst_pkg::SAMPLE_W-1:0] r;
      if (q > Q_W'(ppst_pkg::MAX_POS)) begin
         r = ppst_pkg::MAX_POS;
      end else if (q < Q_W'(ppst_pkg::MIN_NEG)) begin
         r = ppst_pkg::MIN_NEG;
      end else begin
         r = q[ppst_pkg::SAMPLE_W-1:0];
      end
      return r;
   endfunction

   // Stage 2 holds the raw products.
   logic                      v2_ff, v2_in;
   logic signed [PROD_W-1:0]  pre_ff, pre_in, pim_ff, pim_in;
   logic [ppst_pkg::IDX_W-1:0] x2_ff, z2_ff;
   logic                      last2_ff;
   logic                      en2;

   // Stage 3 holds the saturated coefficient.
   logic                      v3_ff, v3_in;
   ppst_pkg::item_type        d3_ff, d3_in;
   logic                      en3;

   logic signed [ppst_pkg::SCALE_W:0] scale_s;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign in_ready = en2;
   assign v2_in    = en2 ? in_valid : v2_ff;
   assign v3_in    = en3 ? v2_ff : v3_ff;

   // Widen both operands first so the product keeps every bit.
   assign scale_s = $signed({1'b0, scale});
   assign pre_in  = PROD_W'(in_data.re) * PROD_W'(scale_s);
   assign pim_in  = PROD_W'(in_data.im) * PROD_W'(scale_s);

   always_comb begin
      d3_in.re   = sat_q(pre_ff[PROD_W-1:FRAC_W]);
      d3_in.im   = sat_q(pim_ff[PROD_W-1:FRAC_W]);
      d3_in.x    = x2_ff;
      d3_in.z    = z2_ff;
      d3_in.last = last2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         pre_ff   <= pre_in;
         pim_ff   <= pim_in;
         x2_ff    <= in_data.x;
         z2_ff    <= in_data.z;
         last2_ff <= in_data.last;
      end
      if (en3) begin
         d3_ff <= d3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = d3_ff;

endmodule

`default_nettype wire

[rtl/ppst_mag.sv]
// Stages 4 and 5: square both parts, sum and compare against the threshold.
`timescale 1ns / 1ps
`default_nettype none

module ppst_mag (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [ppst_pkg::THRESH_W-1:0]  threshold_sq,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire ppst_pkg::item_type             in_data,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output ppst_pkg::rsp_type                   out_data
);

   localparam int SQ_W = 2 * ppst_pkg::SAMPLE_W;
   localparam int MAG_W = SQ_W - 1;

   logic                       v4_ff, v4_in;
   logic [MAG_W-1:0]           sqr_ff, sqi_ff;
   logic signed [SQ_W-1:0]     sqr_full, sqi_full;
   ppst_pkg::item_type         d4_ff;
   logic                       en4;

   logic                       v5_ff, v5_in;
   ppst_pkg::rsp_type          d5_ff, d5_in;
   logic                       en5;
   logic [ppst_pkg::THRESH_W-1:0] mag;

   assign en5      = !v5_ff || out_ready;
   assign en4      = !v4_ff || en5;
   assign in_ready = en4;
   assign v4_in    = en4 ? in_valid : v4_ff;
   assign v5_in    = en5 ? v4_ff : v5_ff;

   // Squares are non-negative and at most 2^46.
   assign sqr_full = in_data.re * in_data.re;
   assign sqi_full = in_data.im * in_data.im;

   assign mag = ppst_pkg::THRESH_W'(sqr_ff) + ppst_pkg::THRESH_W'(sqi_ff);

   always_comb begin
      d5_in.keep     = mag > threshold_sq;
      d5_in.out_x    = d4_ff.x;
      d5_in.out_z    = d4_ff.z;
      d5_in.coeff_re = d4_ff.re;
      d5_in.coeff_im = d4_ff.im;
      d5_in.last_out = d4_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         sqr_ff <= sqr_full[MAG_W-1:0];
         sqi_ff <= sqi_full[MAG_W-1:0];
         d4_ff  <= in_data;
      end
      if (en5) begin
         d5_ff <= d5_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_data  = d5_ff;

endmodule

`default_nettype wire

[rtl/pauli_phase_scale_threshold_core.sv]
// Top level of the phase, scale and threshold core.
//
//   channel  direction  handshake                  beat
//   req_     in         req_valid / req_ready      one sample with x, z, last mark
//   rsp_     out        rsp_valid / rsp_ready      keep flag, x, z, coefficient, last
//   csr_     in         psel/penable, pready = 1   scale (addr 0), threshold_sq (addr 8)
//
// Five register stages: phase, scale multiply, shift and saturate, square, sum and
// compare. One beat per cycle is taken while rsp does not stall. Each stage advances
// when it is empty or the next one takes its beat, so a stall on rsp fills the bubbles
// first and then holds req_ready low.
// Synchronous reset empties every stage and loads scale with 1.0 and threshold_sq with 0.
`timescale 1ns / 1ps
`default_nettype none

module pauli_phase_scale_threshold_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire ppst_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output ppst_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [ppst_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [ppst_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ppst_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   logic [ppst_pkg::SCALE_W-1:0]  scale;
   logic [ppst_pkg::THRESH_W-1:0] threshold_sq;

   logic               ph_valid, ph_ready;
   ppst_pkg::item_type ph_data;
   logic               sc_valid, sc_ready;
   ppst_pkg::item_type sc_data;

   ppst_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .scale        (scale),
      .threshold_sq (threshold_sq)
   );

   ppst_phase u_phase (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (ph_valid),
      .out_ready (ph_ready),
      .out_data  (ph_data)
   );

   ppst_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .scale     (scale),
      .in_valid  (ph_valid),
      .in_ready  (ph_ready),
      .in_data   (ph_data),
      .out_valid (sc_valid),
      .out_ready (sc_ready),
      .out_data  (sc_data)
   );

   ppst_mag u_mag (
      .clock        (clock),
      .reset        (reset),
      .threshold_sq (threshold_sq),
      .in_valid     (sc_valid),
      .in_ready     (sc_ready),
      .in_data      (sc_data),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_data     (rsp_data)
   );

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the phase, scale and threshold core.
`timescale 1ns / 1ps

module tb;
   import ppst_pkg::*;

   localparam int PIPE_LAT = 5;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SCALE  = {REG_SCALE, 3'b000};
   localparam logic [CSR_ADDR_W-1:0] ADDR_THRESH = {REG_THRESHOLD, 3'b000};

   // Quarter turns selected by the low two bits of popcount(x & z).
   localparam logic [1:0] ROT_NONE    = 2'd0;
   localparam logic [1:0] ROT_QUARTER = 2'd1;
   localparam logic [1:0] ROT_HALF    = 2'd2;
   localparam logic [1:0] ROT_THREE   = 2'd3;

   localparam logic [SCALE_W-1:0]  SCALE_MAX  = '1;
   localparam logic [THRESH_W-1:0] THRESH_MAX = '1;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Register copies used to predict the coefficient path.
   logic [SCALE_W-1:0]  cur_scale;
   logic [THRESH_W-1:0] cur_thresh;

   rsp_type expected_coeffs[$];
   int      mismatches;
   int      samples_sent;
   int      results_seen;
   int      kept_seen;
   int      settings_used;
   bit      quiet;
   int      stall_left;

   pauli_phase_scale_threshold_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("timeout with %0d results outstanding", expected_coeffs.size());
      $display("[pauli_phase_scale_threshold_core] ERROR");
      $finish;
   end

   function automatic longint neg_sat(longint v);
      longint r;
      r = -v;
      if (r > longint'(MAX_POS)) r = longint'(MAX_POS);
      return r;
   endfunction

   // Multiply by Q1.24 scale, floor back to Q1.22, clamp to 24 bits.
   function automatic longint scale_sat(longint v);
      longint p;
      p = v * longint'(cur_scale);
      p = p >>> 24;
      if (p > longint'(MAX_POS)) p = longint'(MAX_POS);
      if (p < longint'(MIN_NEG)) p = longint'(MIN_NEG);
      return p;
   endfunction

   function automatic rsp_type phase_scale_predict(req_type s);
      rsp_type          r;
      logic [IDX_W-1:0] x;
      logic [IDX_W-1:0] z;
      logic [1:0]       rot;
      longint           re;
      longint           im;
      longint           cr;
      longint           ci;
      logic [63:0]      mag;
      x   = s.row_x & IDX_MASK;
      z   = s.col_z & IDX_MASK;
      re  = s.sample_re;
      im  = s.sample_im;
      rot = 2'($countones(x & z));
      case (rot)
         ROT_NONE: begin
            cr = re;
            ci = im;
         end
         ROT_QUARTER: begin
            cr = im;
            ci = neg_sat(re);
         end
         ROT_HALF: begin
            cr = neg_sat(re);
            ci = neg_sat(im);
         end
         default: begin
            cr = neg_sat(im);
            ci = re;
         end
      endcase
      cr = scale_sat(cr);
      ci = scale_sat(ci);
      mag = 64'(cr * cr) + 64'(ci * ci);
      r.keep     = (mag > {16'd0, cur_thresh});
      r.out_x    = x;
      r.out_z    = z;
      r.coeff_re = SAMPLE_W'(cr);
      r.coeff_im = SAMPLE_W'(ci);
      r.last_out = s.last_item;
      return r;
   endfunction

   function automatic req_type mk_sample(logic [SAMPLE_W-1:0] re, logic [SAMPLE_W-1:0] im,
                                         logic [IDX_W-1:0] x, logic [IDX_W-1:0] z,
                                         logic last);
      req_type s;
      s.sample_re = re;
      s.sample_im = im;
      s.row_x     = x;
      s.col_z     = z;
      s.last_item = last;
      return s;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_part();
      case ($urandom_range(0, 9))
         0: return MIN_NEG;
         1: return MAX_POS;
         2: return SAMPLE_W'($urandom_range(0, 3)) - SAMPLE_W'(2);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [IDX_W-1:0] pick_index();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return IDX_W'($urandom);
      endcase
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
   endtask

   // Check every result beat against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_data.keep === 1'b1) kept_seen++;
         if (expected_coeffs.size() == 0) begin
            note_mismatch("result beat with nothing expected");
         end else begin
            want = expected_coeffs.pop_front();
            if (rsp_data.keep !== want.keep || rsp_data.out_x !== want.out_x ||
                rsp_data.out_z !== want.out_z || rsp_data.coeff_re !== want.coeff_re ||
                rsp_data.coeff_im !== want.coeff_im ||
                rsp_data.last_out !== want.last_out) begin
               note_mismatch($sformatf(
                  "exp keep=%0b x=%h z=%h re=%0d im=%0d last=%0b / got keep=%0b x=%h z=%h re=%0d im=%0d last=%0b",
                  want.keep, want.out_x, want.out_z, want.coeff_re, want.coeff_im,
                  want.last_out, rsp_data.keep, rsp_data.out_x, rsp_data.out_z,
                  rsp_data.coeff_re, rsp_data.coeff_im, rsp_data.last_out));
            end
         end
      end
   end

   // Random backpressure on the result side; none once quiet is set.
   always @(negedge clock) begin
      if (reset || quiet) begin
         stall_left = 0;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Drive one beat and hold it until accepted.
   task automatic send_sample(input req_type s);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (req_ready !== 1'b1);
      expected_coeffs.push_back(phase_scale_predict(s));
      samples_sent++;
   endtask

   task automatic gap(input int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic send_paced(input req_type s);
      if (!quiet && $urandom_range(0, 5) == 0) gap($urandom_range(1, 4));
      send_sample(s);
   endtask

   // Stop sending and wait until every predicted result has come back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_coeffs.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 2) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] a, input logic [CSR_DATA_W-1:0] d);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= a;
      csr_pwdata  <= d;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_check(input logic [CSR_ADDR_W-1:0] a, input logic [CSR_DATA_W-1:0] want);
      logic [CSR_DATA_W-1:0] got;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= a;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== want)
         note_mismatch($sformatf("register at %h: exp %h got %h", a, want, got));
   endtask

   task automatic load_regs(input logic [SCALE_W-1:0] sc, input logic [THRESH_W-1:0] th);
      drain();
      csr_write(ADDR_SCALE, CSR_DATA_W'(sc));
      csr_write(ADDR_THRESH, CSR_DATA_W'(th));
      cur_scale  = sc;
      cur_thresh = th;
      settings_used++;
      csr_check(ADDR_SCALE, CSR_DATA_W'(sc));
      csr_check(ADDR_THRESH, CSR_DATA_W'(th));
   endtask

   task automatic test_reset_values();
      csr_check(ADDR_SCALE, CSR_DATA_W'(SCALE_RESET));
      csr_check(ADDR_THRESH, CSR_DATA_W'(THRESH_RESET));
   endtask

   // Extremes of both parts under each quarter turn, including negation of the minimum.
   task automatic test_phase_extremes();
      send_sample(mk_sample(MIN_NEG, MAX_POS, 16'h0000, 16'h0000, 1'b0));
      send_sample(mk_sample(MAX_POS, MIN_NEG, 16'h0000, 16'h0000, 1'b0));
      send_sample(mk_sample('0, '0, 16'h0000, 16'hffff, 1'b0));
      send_sample(mk_sample(MIN_NEG, MIN_NEG, 16'h0001, 16'h0001, 1'b0));
      send_sample(mk_sample(MAX_POS, '1, 16'h0001, 16'h0001, 1'b1));
      send_sample(mk_sample(MIN_NEG, MIN_NEG, 16'h0003, 16'h0003, 1'b0));
      send_sample(mk_sample(24'd1, MAX_POS, 16'h0003, 16'h0003, 1'b0));
      send_sample(mk_sample(MIN_NEG, MIN_NEG, 16'h0007, 16'h0007, 1'b0));
      send_sample(mk_sample(MAX_POS, MIN_NEG, 16'h0007, 16'h0007, 1'b0));
      send_sample(mk_sample(MIN_NEG, 24'd1, 16'hffff, 16'hffff, 1'b0));
      send_sample(mk_sample(24'd1, MIN_NEG, 16'hffff, 16'h7fff, 1'b1));
      send_sample(mk_sample(MAX_POS, MAX_POS, 16'hffff, 16'h0000, 1'b0));
   endtask

   // Saturating scale, zero scale, floor rounding and the threshold boundary.
   task automatic test_scale_threshold();
      load_regs(SCALE_MAX, '0);
      send_sample(mk_sample(MAX_POS, MIN_NEG, 16'h0000, 16'h0000, 1'b0));
      send_sample(mk_sample('1, 24'd1, 16'h0000, 16'h0000, 1'b0));
      send_sample(mk_sample(MAX_POS, MAX_POS, 16'h0001, 16'h0001, 1'b1));
      load_regs('0, '0);
      send_sample(mk_sample(MIN_NEG, MAX_POS, 16'h0003, 16'h0001, 1'b0));
      send_sample(mk_sample(MAX_POS, MIN_NEG, 16'h0005, 16'h0007, 1'b1));
      load_regs(SCALE_W'(1) << 23, '0);
      send_sample(mk_sample('1, 24'd1, 16'h0000, 16'h0000, 1'b0));
      send_sample(mk_sample(24'd3, -24'sd3, 16'h0000, 16'h0000, 1'b1));
      load_regs(SCALE_RESET, THRESH_W'(1) << 47);
      send_sample(mk_sample(MIN_NEG, MIN_NEG, 16'h0000, 16'h0000, 1'b0));
      load_regs(SCALE_RESET, (THRESH_W'(1) << 47) - THRESH_W'(1));
      send_sample(mk_sample(MIN_NEG, MIN_NEG, 16'h0000, 16'h0000, 1'b1));
      load_regs(SCALE_RESET, THRESH_MAX);
      send_sample(mk_sample(MIN_NEG, MIN_NEG, 16'h0003, 16'h0003, 1'b1));
   endtask

   // Mostly row sweeps ending on a last mark, with loose random beats mixed in.
   task automatic run_random_samples(input int n);
      int               done;
      int               width;
      logic [IDX_W-1:0] x;
      logic [IDX_W-1:0] z0;
      done = 0;
      while (done < n) begin
         if ($urandom_range(0, 3) == 0) begin
            send_paced(mk_sample(pick_part(), pick_part(), pick_index(), pick_index(),
                                 1'($urandom)));
            done++;
         end else begin
            width = $urandom_range(1, 16);
            x     = pick_index();
            z0    = ($urandom_range(0, 1) == 0) ? '0 : IDX_W'($urandom);
            for (int i = 0; i < width; i++) begin
               send_paced(mk_sample(pick_part(), pick_part(), x, z0 + IDX_W'(i),
                                    1'(i == width - 1)));
            end
            done += width;
         end
      end
   endtask

   task automatic test_random_settings();
      logic [SCALE_W-1:0]  sc;
      logic [THRESH_W-1:0] th;
      for (int p = 0; p < 8; p++) begin
         case ($urandom_range(0, 3))
            0: sc = SCALE_W'(1) << $urandom_range(12, 24);
            1: sc = SCALE_W'($urandom);
            2: sc = SCALE_RESET;
            default: sc = SCALE_W'($urandom_range(0, 1 << 24));
         endcase
         th = THRESH_W'({$urandom, $urandom}) >> $urandom_range(0, 20);
         if (p == 0) sc = SCALE_MAX;
         if (p == 1) th = '0;
         if (p == 2) th = THRESH_MAX;
         load_regs(sc, th);
         run_random_samples(160);
      end
   endtask

   // Full rate on both sides to close the run.
   task automatic test_full_rate();
      load_regs(SCALE_W'(1) << 20, THRESH_W'(1) << 36);
      quiet = 1'b1;
      run_random_samples(150);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b1;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      cur_scale     = SCALE_RESET;
      cur_thresh    = THRESH_RESET;
      mismatches    = 0;
      samples_sent  = 0;
      results_seen  = 0;
      kept_seen     = 0;
      settings_used = 1;
      quiet         = 1'b0;
      stall_left    = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_phase_extremes();
      test_scale_threshold();
      test_random_settings();
      test_full_rate();
      drain();

      $display("ran %0d samples through %0d register settings, all four phase turns",
               samples_sent, settings_used);
      $display("%0d results checked, %0d kept, %0d mismatches",
               results_seen, kept_seen, mismatches);
      if (mismatches == 0) begin
         $display("[pauli_phase_scale_threshold_core] OK");
      end else begin
         $display("[pauli_phase_scale_threshold_core] ERROR");
      end
      $finish;
   end

endmodule
